// ----- rtl/core/spg_pkg.sv -----
// Shared constants, tables and types for the superellipse point generator.
// Used by spg_power and superellipse_point_generator; depends on nothing.
package spg_pkg;

  // Field and pipeline sizes
  localparam int IDX_W      = 12;
  localparam int CNT_W      = 13;
  localparam int COORD_W    = 14;
  localparam int PHASE_W    = 16;
  localparam int TRIG_ITERS = 16;
  localparam int POW_STEPS  = 16;
  localparam int POW_LAT    = 1 + POW_STEPS + 1 + POW_STEPS + 1;
  localparam int NSTAGE     = 1 + PHASE_W + TRIG_ITERS + 2 + POW_LAT + 2;

  localparam logic [CNT_W-1:0] MAX_POINTS = 13'd4096;
  localparam logic signed [31:0] CORDIC_GAIN = 32'sd652032875;

  // Configuration register indexes
  typedef enum logic [2:0] {
    REG_CENTER_X    = 3'd0,
    REG_CENTER_Y    = 3'd1,
    REG_RADIUS_X    = 3'd2,
    REG_RADIUS_Y    = 3'd3,
    REG_EXPONENT_X  = 3'd4,
    REG_EXPONENT_Y  = 3'd5,
    REG_POINT_COUNT = 3'd6
  } cfg_reg_t;

  // Arctangent of 2^-k in Q0.24 turns.
  function automatic logic signed [24:0] atan_turn(input int k);
    logic signed [24:0] v;
    case (k)
      0:  v = 25'sd2097152;
      1:  v = 25'sd1238021;
      2:  v = 25'sd654136;
      3:  v = 25'sd332050;
      4:  v = 25'sd166669;
      5:  v = 25'sd83416;
      6:  v = 25'sd41718;
      7:  v = 25'sd20860;
      8:  v = 25'sd10430;
      9:  v = 25'sd5215;
      10: v = 25'sd2608;
      11: v = 25'sd1304;
      12: v = 25'sd652;
      13: v = 25'sd326;
      14: v = 25'sd163;
      15: v = 25'sd81;
      16: v = 25'sd41;
      17: v = 25'sd20;
      18: v = 25'sd10;
      19: v = 25'sd5;
      20: v = 25'sd3;
      21: v = 25'sd1;
      22: v = 25'sd1;
      default: v = 25'sd0;
    endcase
    return v;
  endfunction

  // 2^(-2^-b) in Q1.30.
  function automatic logic [30:0] exp_neg_pow2(input int b);
    logic [30:0] v;
    case (b)
      1:  v = 31'd759250125;
      2:  v = 31'd902905651;
      3:  v = 31'd984625594;
      4:  v = 31'd1028218693;
      5:  v = 31'd1050733751;
      6:  v = 31'd1062175491;
      7:  v = 31'd1067942999;
      8:  v = 31'd1070838486;
      9:  v = 31'd1072289173;
      10: v = 31'd1073015252;
      11: v = 31'd1073378477;
      12: v = 31'd1073560135;
      13: v = 31'd1073650976;
      14: v = 31'd1073696399;
      15: v = 31'd1073719111;
      16: v = 31'd1073730467;
      default: v = 31'd1073741824;
    endcase
    return v;
  endfunction

endpackage

// ----- rtl/core/spg_power.sv -----
// Pipelined power unit: raises a Q1.15 magnitude to a Q4.12 exponent.
// Uses spg_pkg for its step counts and the 2^(-2^-b) table.
module spg_power (
  input  logic        clk,
  input  logic        en,
  input  logic [15:0] mag,
  input  logic [15:0] expo,
  output logic [15:0] result
);

  localparam int N = spg_pkg::POW_STEPS;

  // Normalize the magnitude so its leading one sits at bit 30.
  logic [3:0]  lead;
  logic [30:0] norm;
  always_comb begin
    lead = 4'd0;
    for (int b = 0; b < 15; b++) begin
      if (mag[b]) lead = 4'(b);
    end
    norm = {mag[14:0], 16'b0} << (4'd14 - lead);
  end

  logic [30:0] n_mm;
  logic [3:0]  n_lz;
  logic        n_zero, n_one;
  always_ff @(posedge clk) begin
    if (en) begin
      n_mm   <= norm;
      n_lz   <= 4'd15 - lead;
      n_zero <= (mag == 16'd0);
      n_one  <= mag[15];
    end
  end

  // Log2 by repeated squaring, one fraction bit per stage.
  logic [30:0] sq_mm [0:N-1];
  logic [15:0] sq_fr [0:N-1];
  logic [3:0]  sq_lz [0:N-1];
  logic        sq_zero [0:N-1];
  logic        sq_one  [0:N-1];

  for (genvar k = 0; k < N; k++) begin : g_sq
    logic [30:0] mi;
    logic [15:0] fi;
    logic [3:0]  li;
    logic        zi, oi;
    logic [61:0] sq;
    if (k == 0) begin : g_first
      assign mi = n_mm;
      assign fi = 16'd0;
      assign li = n_lz;
      assign zi = n_zero;
      assign oi = n_one;
    end else begin : g_next
      assign mi = sq_mm[k-1];
      assign fi = sq_fr[k-1];
      assign li = sq_lz[k-1];
      assign zi = sq_zero[k-1];
      assign oi = sq_one[k-1];
    end
    assign sq = mi * mi;
    always_ff @(posedge clk) begin
      if (en) begin
        if (sq[61]) begin
          sq_mm[k] <= sq[61:31];
          sq_fr[k] <= fi | (16'd1 << (N - 1 - k));
        end else begin
          sq_mm[k] <= sq[60:30];
          sq_fr[k] <= fi;
        end
        sq_lz[k]   <= li;
        sq_zero[k] <= zi;
        sq_one[k]  <= oi;
      end
    end
  end

  // Scale the negated log by the exponent.
  logic [19:0] lmag;
  logic [35:0] p_prod;
  logic        p_zero, p_one;
  assign lmag = {sq_lz[N-1], 16'b0} - {4'b0, sq_fr[N-1]};
  always_ff @(posedge clk) begin
    if (en) begin
      p_prod <= lmag * expo;
      p_zero <= sq_zero[N-1];
      p_one  <= sq_one[N-1];
    end
  end

  // Build 2^-f from the fraction, one table factor per stage.
  logic [30:0] e_r  [0:N-1];
  logic [15:0] e_f  [0:N-1];
  logic [7:0]  e_ip [0:N-1];
  logic        e_zero [0:N-1];
  logic        e_one  [0:N-1];

  for (genvar k = 0; k < N; k++) begin : g_exp
    logic [30:0] ri;
    logic [15:0] fi;
    logic [7:0]  ii;
    logic        zi, oi;
    logic [61:0] pr;
    if (k == 0) begin : g_first
      assign ri = 31'h4000_0000;
      assign fi = p_prod[27:12];
      assign ii = p_prod[35:28];
      assign zi = p_zero;
      assign oi = p_one;
    end else begin : g_next
      assign ri = e_r[k-1];
      assign fi = e_f[k-1];
      assign ii = e_ip[k-1];
      assign zi = e_zero[k-1];
      assign oi = e_one[k-1];
    end
    assign pr = ri * spg_pkg::exp_neg_pow2(k + 1);
    always_ff @(posedge clk) begin
      if (en) begin
        e_r[k]    <= fi[N-1-k] ? pr[60:30] : ri;
        e_f[k]    <= fi;
        e_ip[k]   <= ii;
        e_zero[k] <= zi;
        e_one[k]  <= oi;
      end
    end
  end

  // Apply the integer part as a shift and round to Q1.15.
  logic [30:0] shifted;
  logic [31:0] rounded;
  assign shifted = e_r[N-1] >> e_ip[N-1][4:0];
  assign rounded = {1'b0, shifted} + 32'd16384;
  always_ff @(posedge clk) begin
    if (en) begin
      if (e_zero[N-1]) begin
        result <= 16'd0;
      end else if (e_one[N-1]) begin
        result <= 16'd32768;
      end else if (e_ip[N-1] >= 8'd31) begin
        result <= 16'd0;
      end else begin
        result <= rounded[30:15];
      end
    end
  end

endmodule

// ----- rtl/core/superellipse_point_generator.sv -----
// Top level of the superellipse point generator.
// Depends on spg_pkg and spg_power.

// Each request carries a point index and returns one screen point of the
// superellipse: the angle index/point_count of a turn, its sine and cosine,
// each magnitude raised to its exponent, then scaled by the radius and
// offset from the center. The block takes one request per clock; its
// pipeline holds the 16-stage restoring divider that forms the phase, the
// 16 CORDIC stages, and the 35 stages of the power unit with its 33
// registered multiplies. A stall on the result side holds the whole
// pipeline. An index at or above the point count sets index_error and
// returns zero coordinates. Configuration is written through the cfg port
// and is always ready.
module superellipse_point_generator (
  input  logic        clk,
  input  logic        rst,
  // Configuration writes
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data,
  // Requests: s_tdata = point_index[11:0], zero padded
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [15:0] s_tdata,
  // Results: m_tdata = x_pos[13:0], y_pos[27:14], zero padded
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata,
  // m_tuser = index_error[0]
  output logic [0:0]  m_tuser
);

  localparam int NS = spg_pkg::NSTAGE;
  localparam int PL = spg_pkg::POW_LAT;
  localparam int DW = spg_pkg::PHASE_W;
  localparam int TI = spg_pkg::TRIG_ITERS;

  // Configuration registers
  logic [11:0] center_x, center_y, radius_x, radius_y;
  logic [15:0] exponent_x, exponent_y;
  logic [12:0] point_count;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      center_x    <= 12'd320;
      center_y    <= 12'd240;
      radius_x    <= 12'd100;
      radius_y    <= 12'd100;
      exponent_x  <= 16'd4096;
      exponent_y  <= 16'd4096;
      point_count <= 13'd64;
    end else if (cfg_valid) begin
      case (spg_pkg::cfg_reg_t'(cfg_index))
        spg_pkg::REG_CENTER_X:    center_x    <= cfg_data[11:0];
        spg_pkg::REG_CENTER_Y:    center_y    <= cfg_data[11:0];
        spg_pkg::REG_RADIUS_X:    radius_x    <= cfg_data[11:0];
        spg_pkg::REG_RADIUS_Y:    radius_y    <= cfg_data[11:0];
        spg_pkg::REG_EXPONENT_X:  exponent_x  <= cfg_data;
        spg_pkg::REG_EXPONENT_Y:  exponent_y  <= cfg_data;
        spg_pkg::REG_POINT_COUNT: point_count <= cfg_data[12:0];
        default: ;
      endcase
    end
  end

  // Pipeline advance: every stage moves when the output is free or taken.
  logic adv;
  assign adv      = ~m_tvalid | m_tready;
  assign s_tready = adv;

  logic [12:0] count_eff;
  logic        in_err;
  assign count_eff = (point_count > spg_pkg::MAX_POINTS) ? spg_pkg::MAX_POINTS : point_count;
  assign in_err    = ({1'b0, s_tdata[11:0]} >= count_eff);

  // Valid and error flags travel with the data through every stage.
  logic [NS-1:0] vld, err_sr;
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (adv) begin
      vld <= {vld[NS-2:0], s_tvalid};
    end
  end
  always_ff @(posedge clk) begin
    if (adv) err_sr <= {err_sr[NS-2:0], in_err};
  end

  // Input register
  logic [11:0] idx_q;
  always_ff @(posedge clk) begin
    if (adv) idx_q <= s_tdata[11:0];
  end

  // Phase = index * 65536 / count, one quotient bit per stage.
  logic [12:0]   d_r [0:DW-1];
  logic [DW-1:0] d_q [0:DW-1];
  for (genvar k = 0; k < DW; k++) begin : g_div
    logic [12:0]   ri;
    logic [DW-1:0] qi;
    logic [13:0]   r2;
    if (k == 0) begin : g_first
      assign ri = {1'b0, idx_q};
      assign qi = '0;
    end else begin : g_next
      assign ri = d_r[k-1];
      assign qi = d_q[k-1];
    end
    assign r2 = {ri, 1'b0};
    always_ff @(posedge clk) begin
      if (adv) begin
        if (r2 >= {1'b0, count_eff}) begin
          d_r[k] <= 13'(r2 - {1'b0, count_eff});
          d_q[k] <= {qi[DW-2:0], 1'b1};
        end else begin
          d_r[k] <= r2[12:0];
          d_q[k] <= {qi[DW-2:0], 1'b0};
        end
      end
    end
  end

  // Rotation-mode CORDIC over the angle within the quadrant.
  logic signed [31:0] c_x [0:TI-1];
  logic signed [31:0] c_y [0:TI-1];
  logic signed [24:0] c_z [0:TI-1];
  logic [1:0]         c_quad [0:TI-1];
  logic               c_rz   [0:TI-1];
  for (genvar k = 0; k < TI; k++) begin : g_cordic
    logic signed [31:0] xi, yi;
    logic signed [24:0] zi;
    logic [1:0]         qi;
    logic               rzi;
    if (k == 0) begin : g_first
      assign xi  = spg_pkg::CORDIC_GAIN;
      assign yi  = 32'sd0;
      assign zi  = $signed({3'b0, d_q[DW-1][13:0], 8'b0});
      assign qi  = d_q[DW-1][15:14];
      assign rzi = (d_q[DW-1][13:0] == 14'd0);
    end else begin : g_next
      assign xi  = c_x[k-1];
      assign yi  = c_y[k-1];
      assign zi  = c_z[k-1];
      assign qi  = c_quad[k-1];
      assign rzi = c_rz[k-1];
    end
    always_ff @(posedge clk) begin
      if (adv) begin
        if (!zi[24]) begin
          c_x[k] <= xi - (yi >>> k);
          c_y[k] <= yi + (xi >>> k);
          c_z[k] <= zi - spg_pkg::atan_turn(k);
        end else begin
          c_x[k] <= xi + (yi >>> k);
          c_y[k] <= yi - (xi >>> k);
          c_z[k] <= zi + spg_pkg::atan_turn(k);
        end
        c_quad[k] <= qi;
        c_rz[k]   <= rzi;
      end
    end
  end

  // Round to Q1.15, saturate at one, and map the quadrant.
  logic signed [32:0] y_rnd, x_rnd;
  logic signed [17:0] y_sh, x_sh;
  logic signed [16:0] s_cl, c_cl, s_v, c_v;
  assign y_rnd = {c_y[TI-1][31], c_y[TI-1]} + 33'sd16384;
  assign x_rnd = {c_x[TI-1][31], c_x[TI-1]} + 33'sd16384;
  assign y_sh  = 18'(y_rnd >>> 15);
  assign x_sh  = 18'(x_rnd >>> 15);

  always_comb begin
    if (y_sh > 18'sd32768)       s_cl = 17'sd32768;
    else if (y_sh < -18'sd32768) s_cl = -17'sd32768;
    else                         s_cl = 17'(y_sh);
    if (x_sh > 18'sd32768)       c_cl = 17'sd32768;
    else if (x_sh < -18'sd32768) c_cl = -17'sd32768;
    else                         c_cl = 17'(x_sh);
    if (c_rz[TI-1]) begin
      s_v = 17'sd0;
      c_v = 17'sd32768;
    end else begin
      s_v = s_cl;
      c_v = c_cl;
    end
  end

  logic signed [16:0] sn, cs;
  always_ff @(posedge clk) begin
    if (adv) begin
      case (c_quad[TI-1])
        2'd0: begin sn <= s_v;  cs <= c_v;  end
        2'd1: begin sn <= c_v;  cs <= -s_v; end
        2'd2: begin sn <= -s_v; cs <= -c_v; end
        default: begin sn <= -c_v; cs <= s_v; end
      endcase
    end
  end

  // Split into magnitude and sign.
  logic [16:0] sn_abs, cs_abs;
  logic [15:0] mag_x, mag_y;
  logic        neg_x, neg_y;
  assign sn_abs = sn[16] ? 17'(-sn) : 17'(sn);
  assign cs_abs = cs[16] ? 17'(-cs) : 17'(cs);
  always_ff @(posedge clk) begin
    if (adv) begin
      mag_x <= sn_abs[15:0];
      mag_y <= cs_abs[15:0];
      neg_x <= sn[16];
      neg_y <= cs[16];
    end
  end

  // Power units, with the signs delayed alongside.
  logic [15:0]   pow_x, pow_y;
  logic [PL-1:0] negx_sr, negy_sr;
  spg_power u_pow_x (.clk(clk), .en(adv), .mag(mag_x), .expo(exponent_x), .result(pow_x));
  spg_power u_pow_y (.clk(clk), .en(adv), .mag(mag_y), .expo(exponent_y), .result(pow_y));
  always_ff @(posedge clk) begin
    if (adv) begin
      negx_sr <= {negx_sr[PL-2:0], neg_x};
      negy_sr <= {negy_sr[PL-2:0], neg_y};
    end
  end

  // Scale by the radii.
  logic [27:0] prod_x, prod_y;
  logic        pneg_x, pneg_y;
  always_ff @(posedge clk) begin
    if (adv) begin
      prod_x <= radius_x * pow_x;
      prod_y <= radius_y * pow_y;
      pneg_x <= negx_sr[PL-1];
      pneg_y <= negy_sr[PL-1];
    end
  end

  // Add the center and truncate toward zero.
  logic signed [29:0] sum_x, sum_y, term_x, term_y;
  logic signed [29:0] q_x, q_y;
  assign term_x = $signed({2'b0, prod_x});
  assign term_y = $signed({2'b0, prod_y});
  assign sum_x  = $signed({3'b0, center_x, 15'b0}) + (pneg_x ? -term_x : term_x);
  assign sum_y  = $signed({3'b0, center_y, 15'b0}) - (pneg_y ? -term_y : term_y);
  assign q_x    = (sum_x >>> 15) + ((sum_x[29] && (sum_x[14:0] != 15'd0)) ? 30'sd1 : 30'sd0);
  assign q_y    = (sum_y >>> 15) + ((sum_y[29] && (sum_y[14:0] != 15'd0)) ? 30'sd1 : 30'sd0);

  // Output register
  always_ff @(posedge clk) begin
    if (adv) begin
      if (err_sr[NS-2]) begin
        m_tdata <= 32'd0;
        m_tuser <= 1'b1;
      end else begin
        m_tdata <= {4'b0, q_y[13:0], q_x[13:0]};
        m_tuser <= 1'b0;
      end
    end
  end

  assign m_tvalid = vld[NS-1];

endmodule

// ----- tb/tb_superellipse_point_generator.sv -----
// Self-checking testbench for the superellipse point generator.
// Depends on spg_pkg and the superellipse_point_generator RTL;
// predicts points in fixed point or takes typed-in expectations.
module tb_superellipse_point_generator;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int LATENCY = 72;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [2:0]  cfg_index = '0;
  logic [15:0] cfg_data = '0;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [15:0] s_tdata = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [31:0] m_tdata;
  logic [0:0]  m_tuser;

  typedef struct packed {
    logic [13:0] x_pos;
    logic [13:0] y_pos;
    logic        index_error;
  } point_t;

  // Local copy of the configuration registers
  logic [11:0] cen_x, cen_y, rad_x, rad_y;
  logic [15:0] exp_x, exp_y;
  logic [12:0] npts;

  point_t      pending_points[$];
  int          errors = 0;
  int          points_checked = 0;
  int          send_idle_pct = 0;
  int          recv_stall_pct = 0;
  bit          hold_off = 1'b0;

  superellipse_point_generator dut (.*);

  always #10 clk = ~clk;

  // Arithmetic shift right, rounding toward minus infinity.
  function automatic longint asr_floor(longint v, int k);
    return v >>> k;
  endfunction

  function automatic longint clamp_unit(longint v);
    if (v > 32768) return 32768;
    if (v < -32768) return -32768;
    return v;
  endfunction

  function automatic longint atan_q24(int k);
    longint tbl[24] = '{2097152, 1238021, 654136, 332050, 166669, 83416, 41718, 20860,
                        10430, 5215, 2608, 1304, 652, 326, 163, 81,
                        41, 20, 10, 5, 3, 1, 1, 0};
    return tbl[k];
  endfunction

  function automatic longint unsigned exp2_neg(int b);
    longint unsigned tbl[17] = '{1073741824, 759250125, 902905651, 984625594,
                                 1028218693, 1050733751, 1062175491, 1067942999,
                                 1070838486, 1072289173, 1073015252, 1073378477,
                                 1073560135, 1073650976, 1073696399, 1073719111,
                                 1073730467};
    return tbl[b];
  endfunction

  // Magnitude raised to a Q4.12 exponent, via log2 and 2^-f.
  function automatic longint unsigned raise_q15(longint unsigned u, longint unsigned e);
    int p;
    longint unsigned mm, frac, lmag, prod, ipart, f16, r;
    frac = 0;
    if (u == 0) return 0;
    if (u >= 32768) return 32768;
    p = 14;
    while (p > 0 && ((u >> p) & 1) == 0) p--;
    mm = (u << (15 - p)) << 15;
    for (int b = 0; b < 16; b++) begin
      mm = (mm * mm) >> 30;
      if (mm >= (64'd1 << 31)) begin
        mm = mm >> 1;
        frac |= 64'd1 << (15 - b);
      end
    end
    lmag = (longint'(15 - p) << 16) - frac;
    prod = lmag * e;
    ipart = prod >> 28;
    if (ipart >= 31) return 0;
    f16 = (prod >> 12) & 16'hFFFF;
    r = 64'd1 << 30;
    for (int b = 1; b <= 16; b++)
      if ((f16 >> (16 - b)) & 1) r = (r * exp2_neg(b)) >> 30;
    r = r >> ipart;
    return (r + 16384) >> 15;
  endfunction

  // Expected screen point for one index under the current registers.
  function automatic point_t locate_point(logic [11:0] idx);
    point_t pt;
    longint unsigned cnt, px, py;
    longint x, y, z, dx, dy, s, c, sn, cs, xs, ys;
    logic [15:0] phase;
    logic [13:0] rem;
    cnt = (npts > spg_pkg::MAX_POINTS) ? 4096 : npts;
    pt = '0;
    if (idx >= cnt) begin
      pt.index_error = 1'b1;
      return pt;
    end
    phase = 16'((longint'(idx) << 16) / cnt);
    rem = phase[13:0];
    if (rem == 0) begin
      s = 0;
      c = 32768;
    end else begin
      x = 652032875;
      y = 0;
      z = longint'(rem) << 8;
      for (int k = 0; k < spg_pkg::TRIG_ITERS; k++) begin
        dx = asr_floor(y, k);
        dy = asr_floor(x, k);
        if (z >= 0) begin
          x -= dx; y += dy; z -= atan_q24(k);
        end else begin
          x += dx; y -= dy; z += atan_q24(k);
        end
      end
      s = clamp_unit(asr_floor(y + 16384, 15));
      c = clamp_unit(asr_floor(x + 16384, 15));
    end
    case (phase[15:14])
      2'd0: begin sn = s; cs = c; end
      2'd1: begin sn = c; cs = -s; end
      2'd2: begin sn = -s; cs = -c; end
      default: begin sn = -c; cs = s; end
    endcase
    px = raise_q15(sn < 0 ? -sn : sn, exp_x);
    py = raise_q15(cs < 0 ? -cs : cs, exp_y);
    xs = longint'(cen_x) * 32768 + (sn < 0 ? -1 : 1) * longint'(rad_x) * longint'(px);
    ys = longint'(cen_y) * 32768 - (cs < 0 ? -1 : 1) * longint'(rad_y) * longint'(py);
    pt.x_pos = 14'(xs / 32768);
    pt.y_pos = 14'(ys / 32768);
    return pt;
  endfunction

  // One register write, after which the channel idles before the task returns.
  task automatic write_reg(spg_pkg::cfg_reg_t idx, logic [15:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      spg_pkg::REG_CENTER_X:    cen_x = val[11:0];
      spg_pkg::REG_CENTER_Y:    cen_y = val[11:0];
      spg_pkg::REG_RADIUS_X:    rad_x = val[11:0];
      spg_pkg::REG_RADIUS_Y:    rad_y = val[11:0];
      spg_pkg::REG_EXPONENT_X:  exp_x = val;
      spg_pkg::REG_EXPONENT_Y:  exp_y = val;
      spg_pkg::REG_POINT_COUNT: npts  = val[12:0];
      default: ;
    endcase
    @(posedge clk);
  endtask

  // Wait until every outstanding point has returned, plus pipeline drain.
  task automatic drain();
    while (pending_points.size() != 0) @(posedge clk);
    repeat (LATENCY + 8) @(posedge clk);
  endtask

  // Offer one request; optional expected value typed in directly.
  task automatic send_index(logic [11:0] idx, bit typed = 0, point_t want = '0);
    if ($urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {4'd0, idx};
    do @(posedge clk); while (!s_tready);
    pending_points = {pending_points, (typed ? want : locate_point(idx))};
  endtask

  // Output checker: compare each result with the oldest expectation.
  always @(posedge clk) begin
    point_t got, want;
    if (!rst && m_tvalid && m_tready) begin
      got.x_pos = m_tdata[13:0];
      got.y_pos = m_tdata[27:14];
      got.index_error = m_tuser[0];
      if (pending_points.size() == 0) begin
        $display("%0t unexpected point x=%0d y=%0d err=%0b", $time,
                 got.x_pos, got.y_pos, got.index_error);
        errors++;
      end else begin
        want = pending_points.pop_front();
        points_checked++;
        if (got !== want) begin
          $display("%0t mismatch: expected x=%0d y=%0d err=%0b, actual x=%0d y=%0d err=%0b",
                   $time, want.x_pos, want.y_pos, want.index_error,
                   got.x_pos, got.y_pos, got.index_error);
          errors++;
        end
      end
    end
  end

  // Receiver ready, with random stalls and one long hold-off.
  always @(posedge clk) begin
    if (rst || hold_off) m_tready <= 1'b0;
    else m_tready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // Hold-off stretch counted in cycles of its own.
  task automatic long_hold();
    hold_off = 1'b1;
    for (int n = 0; n < 300; n++) @(posedge clk);
    hold_off = 1'b0;
  endtask

  // Random mix of register settings, extremes included.
  task automatic random_config();
    logic [15:0] v;
    write_reg(spg_pkg::REG_CENTER_X, $urandom_range(3) == 0 ? 16'hFFF : 16'($urandom));
    write_reg(spg_pkg::REG_CENTER_Y, $urandom_range(3) == 0 ? 16'h000 : 16'($urandom));
    write_reg(spg_pkg::REG_RADIUS_X, $urandom_range(3) == 0 ? 16'hFFF : 16'($urandom));
    write_reg(spg_pkg::REG_RADIUS_Y, 16'($urandom));
    case ($urandom_range(3))
      0: v = 16'hFFFF;
      1: v = 16'd1;
      default: v = 16'($urandom_range(1, 16384));
    endcase
    write_reg(spg_pkg::REG_EXPONENT_X, v);
    write_reg(spg_pkg::REG_EXPONENT_Y,
              $urandom_range(4) == 0 ? 16'h0000 : 16'($urandom));
    case ($urandom_range(3))
      0: v = 16'h1FFF;
      1: v = 16'd1;
      default: v = 16'($urandom_range(1, 4096));
    endcase
    write_reg(spg_pkg::REG_POINT_COUNT, v);
  endtask

  // Directed rows: index, typed expectation flag, expected point.
  typedef struct {
    logic [11:0] idx;
    bit          typed;
    point_t      want;
  } row_t;

  initial begin
    row_t rows[9];
    int cnt_now;
    logic [11:0] idx;
    cen_x = 320; cen_y = 240; rad_x = 100; rad_y = 100;
    exp_x = 4096; exp_y = 4096; npts = 64;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // After reset: circle quarter points, out-of-range and computed indexes.
    rows = '{'{12'd0,    1'b1, '{14'd320, 14'd140, 1'b0}},
             '{12'd16,   1'b1, '{14'd420, 14'd240, 1'b0}},
             '{12'd32,   1'b1, '{14'd320, 14'd340, 1'b0}},
             '{12'd48,   1'b1, '{14'd220, 14'd240, 1'b0}},
             '{12'd64,   1'b1, '{14'd0, 14'd0, 1'b1}},
             '{12'd4095, 1'b1, '{14'd0, 14'd0, 1'b1}},
             '{12'd63,   1'b0, '{14'd0, 14'd0, 1'b0}},
             '{12'd5,    1'b0, '{14'd0, 14'd0, 1'b0}},
             '{12'd37,   1'b0, '{14'd0, 14'd0, 1'b0}}};
    foreach (rows[i]) send_index(rows[i].idx, rows[i].typed, rows[i].want);
    s_tvalid <= 1'b0;
    drain();

    // Extremes: top radii, edge centers, count above bound, zero exponent.
    write_reg(spg_pkg::REG_CENTER_X, 16'hFFF);
    write_reg(spg_pkg::REG_CENTER_Y, 16'h000);
    write_reg(spg_pkg::REG_RADIUS_X, 16'hFFF);
    write_reg(spg_pkg::REG_RADIUS_Y, 16'hFFF);
    write_reg(spg_pkg::REG_EXPONENT_X, 16'h0000);
    write_reg(spg_pkg::REG_EXPONENT_Y, 16'hFFFF);
    write_reg(spg_pkg::REG_POINT_COUNT, 16'h1FFF);
    foreach (rows[i]) if (i < 4) send_index(12'(rows[i].idx * 64));
    send_index(12'd4095);
    send_index(12'd1);
    send_index(12'd2048);
    s_tvalid <= 1'b0;
    drain();
    write_reg(spg_pkg::REG_POINT_COUNT, 16'd0);
    send_index(12'd0, 1, '{14'd0, 14'd0, 1'b1});
    s_tvalid <= 1'b0;
    drain();
    write_reg(spg_pkg::REG_POINT_COUNT, 16'd1);
    write_reg(spg_pkg::REG_EXPONENT_X, 16'd1);
    send_index(12'd0);
    send_index(12'd1, 1, '{14'd0, 14'd0, 1'b1});
    s_tvalid <= 1'b0;
    drain();

    // Random phases with idling patterns cycling through each phase.
    for (int ph = 0; ph < 16; ph++) begin
      case (ph % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 45; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 45; end
        default: begin send_idle_pct = 29; recv_stall_pct = 29; end
      endcase
      random_config();
      if (ph == 2) fork long_hold(); join_none
      cnt_now = (npts > spg_pkg::MAX_POINTS) ? 4096 : npts;
      for (int n = 0; n < 100; n++) begin
        if ($urandom_range(9) == 0) idx = 12'($urandom);
        else idx = 12'($urandom_range(cnt_now - 1));
        send_index(idx);
      end
      s_tvalid <= 1'b0;
      drain();
    end

    $display("Covered %0d points over 16 random register settings and four idling mixes,",
             points_checked);
    $display("including a long receiver hold-off and out-of-range indexes.");
    if (errors == 0 && pending_points.size() == 0) begin
      $display("tb_superellipse_point_generator OK");
    end else begin
      $display("tb_superellipse_point_generator NOT OK");
    end
    $finish;
  end

  // Timeout guard.
  initial begin
    #20ms;
    $display("tb_superellipse_point_generator NOT OK");
    $finish;
  end

endmodule

// ----- filelist.f -----
rtl/core/spg_pkg.sv
rtl/core/spg_power.sv
rtl/core/superellipse_point_generator.sv
tb/tb_superellipse_point_generator.sv
